>>> rtl/mdws_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mdws_pkg: shared constants and types
// Widths, table sizes and the control encoding of the distinct-window
// maximum-sum block.
// ----------------------------------------------------------------------------
package mdws_pkg;

  localparam int VALUE_BITS  = 12;
  localparam int MAX_WINDOW  = 256;
  localparam int VALUE_COUNT = 1 << VALUE_BITS;
  localparam int SLOT_BITS   = $clog2(MAX_WINDOW);
  localparam int LEN_BITS    = 9;
  localparam int CNT_BITS    = $clog2(MAX_WINDOW) + 1;
  localparam int SUM_BITS    = 20;
  localparam int SUR_BITS    = 9;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_RUN,
    ST_FLUSH
  } st_t;

  // Work in flight between the read and the write-back of the count tables.
  typedef struct packed {
    logic                  sweep;
    logic [VALUE_BITS-1:0] value;
    logic [VALUE_BITS-1:0] old;
    logic                  evict;
    logic                  full;
    logic                  last;
    logic [SUM_BITS-1:0]   total;
  } s1_t;

endpackage
`default_nettype wire

>>> rtl/mdws_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mdws_in_if: input item channel
// Valid/ready channel carrying one stream value and its last flag per beat.
// ----------------------------------------------------------------------------
interface mdws_in_if import mdws_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] value;
  logic                  last_value;

  modport source (output valid, output value, output last_value, input ready);
  modport sink   (input valid, input value, input last_value, output ready);
endinterface
`default_nettype wire

>>> rtl/mdws_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mdws_out_if: result channel
// Valid/ready channel carrying one best-sum result per beat.
// ----------------------------------------------------------------------------
interface mdws_out_if import mdws_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SUM_BITS-1:0] best_sum;

  modport source (output valid, output best_sum, input ready);
  modport sink   (input valid, input best_sum, output ready);
endinterface
`default_nettype wire

>>> rtl/mdws_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mdws_ram: generic simple dual-port RAM
// One write port and one read port, read data registered (old data on a
// same-address read and write).
// ----------------------------------------------------------------------------
module mdws_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> rtl/max_distinct_window_sum_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// max_distinct_window_sum_top: best sum of a window of distinct values
// Tracks every full window of K consecutive values and keeps the largest
// window sum whose values are all distinct.
//
// Channels: item (sink) carries value and last_value; result (source) carries
// best_sum, one beat per stream, sent for the beat flagged last (0 when no
// window of the stream was full). cfg_wr_en/cfg_wr_data load K; a value of 0
// acts as 1 and one above 256 acts as 256. The load is dropped while a stream
// is in progress.
// Throughput: one item per cycle within a stream while the spare result entry
// is empty. Each beat reads the window RAM and reads and writes the two count
// tables; forwarding covers beats that touch the same count entry in adjacent
// cycles. After the last beat is accepted, best_sum passes through the stage 1
// registers and the result buffer. The block then retires the min(N, K) values
// of the last window (N = stream length) from the count tables; item.ready is
// low meanwhile.
// Reset: a clearing pass zeroes all 4096 count entries; item.ready stays low
// until it ends. Configuration writes are taken during it.
// Stall: results queue in a two-entry output buffer; item.ready drops while
// the second entry is occupied.
// ----------------------------------------------------------------------------
module max_distinct_window_sum_top import mdws_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wr_en,
  input  logic [LEN_BITS-1:0] cfg_wr_data,
  mdws_in_if.sink             item,
  mdws_out_if.source          result
);

  st_t                   state, state_next;
  logic [VALUE_BITS-1:0] clr_idx;
  logic [LEN_BITS-1:0]   k_len, k_len_next;
  logic [LEN_BITS-1:0]   items_seen, items_seen_next, seen_inc;
  logic [LEN_BITS-1:0]   sweep_cnt;
  logic [SLOT_BITS-1:0]  ring_pos, ring_pos_next, ring_inc;
  logic [SLOT_BITS-1:0]  sweep_pos, sweep_pos_next;
  logic [SUM_BITS-1:0]   total, total_sum;
  logic [SUM_BITS-1:0]   best, best_next;
  logic [SUR_BITS-1:0]   surplus, sur_a, sur_b;

  logic                  accept, evict0, full0;
  logic [SLOT_BITS-1:0]  win_raddr;
  logic [VALUE_BITS-1:0] win_rdata, old_val, byp_data;
  logic                  byp_hit;

  logic                  s1_valid;
  s1_t                   s1;

  logic                  cnt_clear;
  logic                  inc_we, dec_we;
  logic [VALUE_BITS-1:0] inc_wa, dec_wa;
  logic [CNT_BITS-1:0]   inc_wd, dec_wd;
  logic [CNT_BITS-1:0]   inc_a_rd, inc_b_rd, dec_a_rd, dec_b_rd;
  logic                  f_iv, f_io, f_dv, f_do;
  logic [CNT_BITS-1:0]   f_inc_data, f_dec_data;
  logic [CNT_BITS-1:0]   iv, io, dv, dec_o;
  logic [CNT_BITS-1:0]   cnt_o_rest, cnt_v;
  logic                  same_val;
  logic                  push;

  logic                  out_valid, spare_valid, pop;
  logic [SUM_BITS-1:0]   out_data, spare_data;

  // Handshakes
  assign item.ready      = (state == ST_RUN) && !spare_valid;
  assign accept          = item.valid && item.ready;
  assign result.valid    = out_valid;
  assign result.best_sum = out_data;
  assign pop             = out_valid && result.ready;

  // Effective window length
  always_comb begin
    k_len_next = k_len;
    if (cfg_wr_en && (items_seen == '0)) begin
      if (cfg_wr_data == '0) begin
        k_len_next = LEN_BITS'(1);
      end else if (cfg_wr_data > LEN_BITS'(MAX_WINDOW)) begin
        k_len_next = LEN_BITS'(MAX_WINDOW);
      end else begin
        k_len_next = cfg_wr_data;
      end
    end
  end

  // Stage 0: window slot, counters, running sum
  assign old_val  = byp_hit ? byp_data : win_rdata;
  assign evict0   = items_seen >= k_len;
  assign seen_inc = (items_seen < k_len) ? items_seen + LEN_BITS'(1) : items_seen;
  assign full0    = seen_inc >= k_len;
  assign ring_inc = (LEN_BITS'(ring_pos) + LEN_BITS'(1) == k_len) ? '0
                  : ring_pos + SLOT_BITS'(1);
  assign total_sum = total
                   - (evict0 ? SUM_BITS'(old_val) : '0)
                   + SUM_BITS'(item.value);

  always_comb begin
    state_next      = state;
    ring_pos_next   = ring_pos;
    items_seen_next = items_seen;
    sweep_pos_next  = sweep_pos;
    unique case (state)
      ST_CLEAR: begin
        if (&clr_idx) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (accept) begin
          if (item.last_value) begin
            state_next      = ST_FLUSH;
            ring_pos_next   = '0;
            items_seen_next = '0;
            sweep_pos_next  = '0;
          end else begin
            ring_pos_next   = ring_inc;
            items_seen_next = seen_inc;
          end
        end
      end
      ST_FLUSH: begin
        sweep_pos_next = sweep_pos + SLOT_BITS'(1);
        if (LEN_BITS'(sweep_pos) + LEN_BITS'(1) == sweep_cnt) begin
          state_next = ST_RUN;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  assign win_raddr = (state_next == ST_FLUSH) ? sweep_pos_next : ring_pos_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clr_idx    <= '0;
      k_len      <= LEN_BITS'(1);
      items_seen <= '0;
      ring_pos   <= '0;
      sweep_pos  <= '0;
      sweep_cnt  <= '0;
      total      <= '0;
      s1_valid   <= 1'b0;
    end else begin
      state      <= state_next;
      k_len      <= k_len_next;
      items_seen <= items_seen_next;
      ring_pos   <= ring_pos_next;
      sweep_pos  <= sweep_pos_next;
      s1_valid   <= accept || (state == ST_FLUSH);
      if (state == ST_CLEAR) begin
        clr_idx <= clr_idx + VALUE_BITS'(1);
      end
      if (accept) begin
        total <= item.last_value ? '0 : total_sum;
        if (item.last_value) begin
          sweep_cnt <= seen_inc;
        end
      end
    end
  end

  // Stage 1 payload; a flush step retires one windowed value
  always_ff @(posedge clk) begin
    byp_hit  <= accept && (ring_pos == win_raddr);
    byp_data <= item.value;
    s1.sweep <= (state == ST_FLUSH);
    s1.value <= item.value;
    s1.old   <= old_val;
    s1.evict <= (state == ST_FLUSH) || evict0;
    s1.full  <= full0;
    s1.last  <= item.last_value;
    s1.total <= total_sum;
  end

  mdws_ram #(.WIDTH(VALUE_BITS), .DEPTH(MAX_WINDOW)) u_win_ram (
    .clk   (clk),
    .we    (accept),
    .waddr (ring_pos),
    .wdata (item.value),
    .raddr (win_raddr),
    .rdata (win_rdata)
  );

  // Count tables: insertions and evictions per value, count = ins - evict
  assign cnt_clear = (state == ST_CLEAR);
  assign inc_we    = cnt_clear || (s1_valid && !s1.sweep);
  assign inc_wa    = cnt_clear ? clr_idx : s1.value;
  assign inc_wd    = cnt_clear ? '0 : iv + CNT_BITS'(1);
  assign dec_we    = cnt_clear || (s1_valid && s1.evict);
  assign dec_wa    = cnt_clear ? clr_idx : s1.old;
  assign dec_wd    = cnt_clear ? '0 : dec_o + CNT_BITS'(1);

  mdws_ram #(.WIDTH(CNT_BITS), .DEPTH(VALUE_COUNT)) u_inc_a_ram (
    .clk (clk), .we (inc_we), .waddr (inc_wa), .wdata (inc_wd),
    .raddr (item.value), .rdata (inc_a_rd)
  );

  mdws_ram #(.WIDTH(CNT_BITS), .DEPTH(VALUE_COUNT)) u_inc_b_ram (
    .clk (clk), .we (inc_we), .waddr (inc_wa), .wdata (inc_wd),
    .raddr (old_val), .rdata (inc_b_rd)
  );

  mdws_ram #(.WIDTH(CNT_BITS), .DEPTH(VALUE_COUNT)) u_dec_a_ram (
    .clk (clk), .we (dec_we), .waddr (dec_wa), .wdata (dec_wd),
    .raddr (item.value), .rdata (dec_a_rd)
  );

  mdws_ram #(.WIDTH(CNT_BITS), .DEPTH(VALUE_COUNT)) u_dec_b_ram (
    .clk (clk), .we (dec_we), .waddr (dec_wa), .wdata (dec_wd),
    .raddr (old_val), .rdata (dec_b_rd)
  );

  // Forward the write-back that lands in the same cycle as the read
  always_ff @(posedge clk) begin
    f_iv       <= inc_we && (inc_wa == item.value);
    f_io       <= inc_we && (inc_wa == old_val);
    f_dv       <= dec_we && (dec_wa == item.value);
    f_do       <= dec_we && (dec_wa == old_val);
    f_inc_data <= inc_wd;
    f_dec_data <= dec_wd;
  end

  assign iv    = f_iv ? f_inc_data : inc_a_rd;
  assign io    = f_io ? f_inc_data : inc_b_rd;
  assign dv    = f_dv ? f_dec_data : dec_a_rd;
  assign dec_o = f_do ? f_dec_data : dec_b_rd;

  // Stage 1: duplicate tracking and best sum
  assign same_val   = s1.evict && (s1.old == s1.value);
  assign cnt_o_rest = io - dec_o - CNT_BITS'(1);
  assign cnt_v      = iv - dv - (same_val ? CNT_BITS'(1) : '0);
  assign sur_a      = (s1.evict && (cnt_o_rest != '0) && (surplus != '0))
                    ? surplus - SUR_BITS'(1) : surplus;
  assign sur_b      = ((cnt_v != '0) && (sur_a != '1)) ? sur_a + SUR_BITS'(1) : sur_a;
  assign best_next  = (s1.full && (sur_b == '0) && (s1.total > best)) ? s1.total : best;
  assign push       = s1_valid && !s1.sweep && s1.last;

  always_ff @(posedge clk) begin
    if (rst) begin
      surplus <= '0;
      best    <= '0;
    end else if (s1_valid && !s1.sweep) begin
      surplus <= s1.last ? '0 : sur_b;
      best    <= s1.last ? '0 : best_next;
    end
  end

  // Two-entry result buffer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      spare_valid <= 1'b0;
    end else if (pop) begin
      out_valid   <= spare_valid || push;
      spare_valid <= spare_valid && push;
    end else if (push) begin
      out_valid   <= 1'b1;
      spare_valid <= out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_data   <= spare_valid ? spare_data : best_next;
      spare_data <= best_next;
    end else if (push) begin
      if (out_valid) begin
        spare_data <= best_next;
      end else begin
        out_data <= best_next;
      end
    end
  end

  a_spare_behind_out: assert property (@(posedge clk) disable iff (rst)
    spare_valid |-> out_valid)
    else $error("result spare entry holds a beat while the head is empty");

  a_seen_bounded: assert property (@(posedge clk) disable iff (rst)
    items_seen <= k_len)
    else $error("item count exceeds window length");

  a_ring_bounded: assert property (@(posedge clk) disable iff (rst)
    LEN_BITS'(ring_pos) < k_len)
    else $error("ring position outside window");

  a_last_flush: assert property (@(posedge clk) disable iff (rst)
    (accept && item.last_value) |=> ((state == ST_FLUSH) && push))
    else $error("last beat did not start flush and result");

  a_push_origin: assert property (@(posedge clk) disable iff (rst)
    push |-> $past(accept && item.last_value))
    else $error("result produced without a last beat");

endmodule
`default_nettype wire

>>> bench/tb_max_distinct_window_sum_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_max_distinct_window_sum_top: self-checking bench for the window sum block
// Streams of values go in over the item channel under several window
// lengths. An in-bench model of the window tracks every full window and
// predicts best_sum for each stream. Each result beat is checked against the
// oldest prediction. Both channels idle at random. Twice the result side
// holds off long enough to back the block up. Length changes are made only
// after the block has drained.
// ----------------------------------------------------------------------------
module tb_max_distinct_window_sum_top;
  import mdws_pkg::*;

  typedef struct packed {
    logic [VALUE_BITS-1:0] value;
    logic                  is_last;
  } beat_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_wr_en = 1'b0;
  logic [LEN_BITS-1:0] cfg_wr_data = '0;

  mdws_in_if  item_ch ();
  mdws_out_if result_ch ();

  max_distinct_window_sum_top DUT (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .item        (item_ch),
    .result      (result_ch)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Window model state
  logic [LEN_BITS-1:0]   length_reg = 9'd1;
  logic [VALUE_BITS-1:0] win_vals [0:MAX_WINDOW-1] = '{default: '0};
  logic [8:0]            occ_count [0:VALUE_COUNT-1] = '{default: '0};
  logic [SUM_BITS-1:0]   win_sum = '0;
  logic [SUR_BITS-1:0]   dup_excess = '0;
  logic [SUM_BITS-1:0]   top_sum = '0;
  logic [LEN_BITS-1:0]   fill = '0;
  logic [SLOT_BITS-1:0]  slot = '0;

  beat_t               pending_beats [$];
  logic [SUM_BITS-1:0] expected_best [$];
  beat_t               next_beat;

  int unsigned cycle_no = 0;
  int          queued_beats = 0;
  int          accepted_beats = 0;
  int          streams_sent = 0;
  int          settings_used = 0;
  int          results_checked = 0;
  int          fail_count = 0;
  int          send_gap = 0;
  int          stall_left = 0;
  int          hold_left = 0;
  int          holds_done = 0;

  function automatic int idle_span(input bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  task automatic step_window(input logic [VALUE_BITS-1:0] v, input logic is_last);
    int                    k;
    int                    pos;
    int                    j;
    logic [VALUE_BITS-1:0] old;
    logic [VALUE_BITS-1:0] w;
    k = int'(length_reg);
    if (k < 1) k = 1;
    if (k > MAX_WINDOW) k = MAX_WINDOW;
    pos = slot % k;
    if (fill >= k) begin
      old = win_vals[pos];
      win_sum = win_sum - SUM_BITS'(old);
      if (occ_count[old] != 0) occ_count[old] = occ_count[old] - 9'd1;
      if (occ_count[old] != 0 && dup_excess != 0) dup_excess = dup_excess - SUR_BITS'(1);
    end
    win_vals[pos] = v;
    win_sum = win_sum + SUM_BITS'(v);
    if (occ_count[v] < 9'h1FF) occ_count[v] = occ_count[v] + 9'd1;
    if (occ_count[v] > 1 && dup_excess < 9'h1FF) dup_excess = dup_excess + SUR_BITS'(1);
    pos = pos + 1;
    if (pos >= k) pos = 0;
    slot = SLOT_BITS'(pos);
    if (fill < k) fill = fill + LEN_BITS'(1);
    if (fill >= k && dup_excess == 0 && win_sum > top_sum) top_sum = win_sum;
    if (is_last) begin
      expected_best.push_back(top_sum);
      for (j = 0; j < fill && j < MAX_WINDOW; j++) begin
        w = win_vals[j];
        if (occ_count[w] != 0) occ_count[w] = occ_count[w] - 9'd1;
      end
      win_sum = '0;
      dup_excess = '0;
      top_sum = '0;
      fill = '0;
      slot = '0;
    end
  endtask

  task automatic queue_beat(input logic [VALUE_BITS-1:0] v, input logic is_last);
    beat_t b;
    b.value = v;
    b.is_last = is_last;
    pending_beats.push_back(b);
    queued_beats++;
    if (is_last) streams_sent++;
  endtask

  task automatic wait_idle;
    while (accepted_beats != queued_beats || expected_best.size() != 0) @(posedge clk);
    // cover the retire pass of up to one full window
    repeat (300) @(posedge clk);
  endtask

  task automatic set_length(input logic [LEN_BITS-1:0] k);
    wait_idle();
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= k;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    length_reg = k;
    settings_used++;
  endtask

  task automatic queue_random_streams(input logic [LEN_BITS-1:0] k_reg, input int budget);
    int                    keff;
    int                    len;
    int                    r;
    int                    mode;
    int                    i;
    int                    base;
    int                    stride;
    logic [VALUE_BITS-1:0] v;
    logic [VALUE_BITS-1:0] made [$];
    keff = int'(k_reg);
    if (keff < 1) keff = 1;
    if (keff > MAX_WINDOW) keff = MAX_WINDOW;
    while (budget > 0) begin
      r = $urandom_range(0, 9);
      if (r < 3 && keff > 1)
        len = $urandom_range(1, (keff - 1 < 16) ? keff - 1 : 16);
      else if (r < 8)
        len = keff + $urandom_range(0, (keff < 10) ? 2 * keff : 20);
      else
        len = keff + $urandom_range(0, (keff < 20) ? 4 * keff : 40);
      mode = $urandom_range(0, 9);
      base = $urandom_range(0, VALUE_COUNT - 1);
      stride = 2 * $urandom_range(0, VALUE_COUNT / 2 - 1) + 1;
      made.delete();
      for (i = 0; i < len; i++) begin
        if (mode < 5) begin
          v = VALUE_BITS'(base + i * stride);
          if (i > 0 && $urandom_range(0, 15) == 0) v = made[$urandom_range(0, i - 1)];
        end else if (mode < 7) begin
          v = VALUE_BITS'(base + $urandom_range(0, keff + 1));
        end else if (mode < 9) begin
          v = VALUE_BITS'($urandom_range(0, VALUE_COUNT - 1));
        end else begin
          v = $urandom_range(0, 1) ? VALUE_BITS'(VALUE_COUNT - 1 - $urandom_range(0, 3))
                                   : VALUE_BITS'($urandom_range(0, 3));
        end
        made.push_back(v);
        queue_beat(v, i == len - 1);
      end
      budget -= len;
    end
  endtask

  always @(posedge clk) cycle_no <= cycle_no + 1;

  // Sender: offer the next pending beat after a random gap
  always @(posedge clk) begin
    if (rst) begin
      item_ch.valid <= 1'b0;
      item_ch.value <= '0;
      item_ch.last_value <= 1'b0;
      send_gap <= 0;
    end else if (!item_ch.valid || item_ch.ready) begin
      if (send_gap != 0) begin
        send_gap <= send_gap - 1;
        item_ch.valid <= 1'b0;
      end else if (pending_beats.size() != 0) begin
        next_beat = pending_beats.pop_front();
        item_ch.value <= next_beat.value;
        item_ch.last_value <= next_beat.is_last;
        item_ch.valid <= 1'b1;
        send_gap <= idle_span((cycle_no % 1500) < 250);
      end else begin
        item_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls plus two long holds to back the block up
  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
      stall_left <= 0;
      hold_left <= 0;
      holds_done <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      result_ch.ready <= 1'b0;
    end else if ((holds_done == 0 && accepted_beats >= 320) ||
                 (holds_done == 1 && accepted_beats >= 490)) begin
      hold_left <= 600;
      holds_done <= holds_done + 1;
      result_ch.ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      result_ch.ready <= 1'b0;
    end else begin
      result_ch.ready <= 1'b1;
      stall_left <= idle_span(((cycle_no + 700) % 1500) < 250);
    end
  end

  // Monitor: check result beats, then advance the model on accepted items
  always @(posedge clk) begin
    if (!rst) begin
      if (result_ch.valid && result_ch.ready) begin
        if (expected_best.size() == 0) begin
          $error("best_sum: expected none, actual %0d", result_ch.best_sum);
          fail_count++;
        end else begin
          if (result_ch.best_sum !== expected_best[0]) begin
            $error("best_sum: expected %0d, actual %0d", expected_best[0], result_ch.best_sum);
            fail_count++;
          end
          void'(expected_best.pop_front());
          results_checked++;
        end
      end
      if (item_ch.valid && item_ch.ready) begin
        accepted_beats <= accepted_beats + 1;
        step_window(item_ch.value, item_ch.last_value);
      end
    end
  end

  initial begin
    int phase_len [10];
    int phase_budget [10];
    int p;
    phase_len = '{0, 1, 2, 3, 5, 8, 17, 64, 256, 511};
    phase_budget = '{60, 100, 100, 80, 80, 80, 80, 100, 60, 60};
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // zero length acts as one; single-beat streams at the value extremes
    set_length(9'd0);
    queue_beat(12'd4095, 1'b1);
    queue_beat(12'd0, 1'b1);
    queue_beat(12'd7, 1'b0);
    queue_beat(12'd7, 1'b1);

    set_length(9'd3);
    queue_beat(12'd1, 1'b0);
    queue_beat(12'd2, 1'b1);
    queue_beat(12'd4095, 1'b0);
    queue_beat(12'd4094, 1'b0);
    queue_beat(12'd4093, 1'b0);
    queue_beat(12'd0, 1'b0);
    queue_beat(12'd4095, 1'b1);
    queue_beat(12'd5, 1'b0);
    queue_beat(12'd5, 1'b0);
    queue_beat(12'd5, 1'b0);
    queue_beat(12'd9, 1'b1);
    queue_beat(12'd10, 1'b0);
    queue_beat(12'd20, 1'b0);
    queue_beat(12'd10, 1'b0);
    queue_beat(12'd30, 1'b0);
    queue_beat(12'd40, 1'b1);

    for (p = 0; p < 10; p++) begin
      set_length(LEN_BITS'(phase_len[p]));
      queue_random_streams(LEN_BITS'(phase_len[p]), phase_budget[p]);
    end

    wait_idle();
    $display("covered %0d streams under %0d window settings: %0d beats, %0d results checked",
             streams_sent, settings_used, accepted_beats, results_checked);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #50_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
